FILE: hdl/signed_row_combination_check_macros.svh
// Assertion macros shared by the signed row combination check checkers.
`ifndef SIGNED_ROW_COMBINATION_CHECK_MACROS_SVH
`define SIGNED_ROW_COMBINATION_CHECK_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SRCC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("srcc check: same-cycle implication failed");

// Next-cycle implication, quiet while reset is asserted.
`define SRCC_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("srcc check: next-cycle implication failed");

// Property checked at every edge, reset included.
`define SRCC_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("srcc check: property failed");

`endif

FILE: hdl/srcc_pkg.sv
// Shared constants and types of the signed row combination check.
package srcc_pkg;

	localparam int ROW_SLOTS  = 7;
	localparam int VEC_LEN    = 4;
	localparam int ROW_W      = 32;
	localparam int KW         = 3;
	localparam int TGT_W      = 3;
	localparam int PAR_W      = 64;
	localparam int MATCH_BITS = 128;

	localparam logic [TGT_W-1:0] ZERO_TARGET = 3'd4;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [KW-1:0]    count_t;

	// What one lane found for its sign pattern.
	typedef struct packed {
		logic pos;
		logic neg;
	} lane_hit_t;

endpackage

FILE: hdl/srcc_channels.sv
// Valid/ready channel interfaces for items and results.
interface srcc_item_if;
	import srcc_pkg::*;

	logic                 valid;
	logic                 ready;
	row_t                 row_zero;
	row_t                 row_one;
	row_t                 row_two;
	row_t                 row_three;
	row_t                 row_four;
	row_t                 row_five;
	row_t                 row_six;
	logic [ROW_SLOTS-1:0] spread_mask;
	logic [TGT_W-1:0]     target_index;

	modport source(
		output valid, row_zero, row_one, row_two, row_three, row_four, row_five, row_six,
		output spread_mask, target_index,
		input ready
	);
	modport sink(
		input valid, row_zero, row_one, row_two, row_three, row_four, row_five, row_six,
		input spread_mask, target_index,
		output ready
	);
endinterface

interface srcc_result_if;
	import srcc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PAR_W-1:0] parity_low;
	logic [PAR_W-1:0] parity_high;
	logic             any_match;

	modport source(output valid, parity_low, parity_high, any_match, input ready);
	modport sink(input valid, parity_low, parity_high, any_match, output ready);
endinterface

FILE: hdl/srcc_compact.sv
// Row unpacking and in-order compaction of the selected rows.
module srcc_compact #(
	parameter int ENTRY_WIDTH = 8,
	parameter int NUM_ROWS    = 7
) (
	input  srcc_pkg::row_t                rows [srcc_pkg::ROW_SLOTS],
	input  logic [srcc_pkg::ROW_SLOTS-1:0] spread_mask,
	output logic signed [ENTRY_WIDTH-1:0] picked [srcc_pkg::ROW_SLOTS][srcc_pkg::VEC_LEN],
	output srcc_pkg::count_t              count
);
	import srcc_pkg::*;

	localparam int FULL_W = VEC_LEN * ENTRY_WIDTH;
	localparam int PAD_W  = (FULL_W > ROW_W) ? FULL_W : ROW_W;

	logic [PAD_W-1:0] padded [ROW_SLOTS];

	// Entries beyond the 32 row bits read as zero.
	always_comb begin
		for (int r = 0; r < ROW_SLOTS; r++) begin
			padded[r] = PAD_W'(rows[r]);
		end
	end

	// Selected rows move down to the next free slot in ascending order.
	always_comb begin
		count = '0;
		for (int r = 0; r < ROW_SLOTS; r++) begin
			for (int c = 0; c < VEC_LEN; c++) begin
				picked[r][c] = '0;
			end
		end
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (spread_mask[r]) begin
				for (int c = 0; c < VEC_LEN; c++) begin
					picked[count][c] = padded[r][c*ENTRY_WIDTH +: ENTRY_WIDTH];
				end
				count = count + 1'b1;
			end
		end
	end

endmodule

FILE: hdl/srcc_lane.sv
// One lane: signed sum for a fixed sign pattern and the two target tests.
module srcc_lane #(
	parameter int ENTRY_WIDTH = 8,
	parameter int NUM_ROWS    = 7,
	parameter int LANE_IDX    = 0
) (
	input  logic signed [ENTRY_WIDTH-1:0] picked [srcc_pkg::ROW_SLOTS][srcc_pkg::VEC_LEN],
	input  logic [srcc_pkg::TGT_W-1:0]    target_index,
	output srcc_pkg::lane_hit_t           hit
);
	import srcc_pkg::*;

	// Seven entries grow the sum by three bits.
	localparam int SUM_W = ENTRY_WIDTH + 3;
	localparam logic signed [SUM_W-1:0] POS_ONE = 1;
	localparam logic signed [SUM_W-1:0] NEG_ONE = -1;

	logic signed [SUM_W-1:0] sum [VEC_LEN];
	logic [VEC_LEN-1:0]      unit_sel;

	// A set pattern bit negates the matching compacted row.
	always_comb begin
		for (int c = 0; c < VEC_LEN; c++) begin
			sum[c] = '0;
			for (int r = 0; r < NUM_ROWS; r++) begin
				if (((LANE_IDX >> r) & 1) != 0) begin
					sum[c] = sum[c] - SUM_W'(picked[r][c]);
				end else begin
					sum[c] = sum[c] + SUM_W'(picked[r][c]);
				end
			end
		end
	end

	// Compare against plus and minus the target vector.
	always_comb begin
		hit.pos = 1'b1;
		hit.neg = 1'b1;
		for (int c = 0; c < VEC_LEN; c++) begin
			unit_sel[c] = (target_index != ZERO_TARGET) && (target_index[1:0] == 2'(c));
			if (unit_sel[c]) begin
				if (sum[c] != POS_ONE) hit.pos = 1'b0;
				if (sum[c] != NEG_ONE) hit.neg = 1'b0;
			end else if (sum[c] != '0) begin
				hit.pos = 1'b0;
				hit.neg = 1'b0;
			end
		end
	end

endmodule

FILE: hdl/srcc_merge.sv
// Merge of lane results into the 128 match bits and the any-match flag.
module srcc_merge #(
	parameter int  NUM_ROWS = 7,
	localparam int LANES    = 1 << (NUM_ROWS - 1)
) (
	input  srcc_pkg::lane_hit_t       hits [LANES],
	input  srcc_pkg::count_t          count,
	output logic [srcc_pkg::PAR_W-1:0] parity_low,
	output logic [srcc_pkg::PAR_W-1:0] parity_high,
	output logic                      any_match
);
	import srcc_pkg::*;

	logic [7:0]            half;
	logic [7:0]            full;
	logic [6:0]            shamt;
	logic [LANES-1:0]      lane_on;
	logic [MATCH_BITS-1:0] pos_v;
	logic [MATCH_BITS-1:0] rev_v;
	logic [MATCH_BITS-1:0] all_v;

	// Only patterns below 2^(k-1) exist; the minus hits land at 2^k-1-i.
	always_comb begin
		half  = (count == '0) ? '0 : 8'(8'd1 << (count - 1'b1));
		full  = 8'(8'd1 << count);
		shamt = 7'(8'd128 - full);
		pos_v = '0;
		rev_v = '0;
		for (int i = 0; i < LANES; i++) begin
			lane_on[i]              = 8'(i) < half;
			pos_v[i]                = hits[i].pos & lane_on[i];
			rev_v[MATCH_BITS-1-i]   = hits[i].neg & lane_on[i];
		end
		all_v = pos_v | (rev_v >> shamt);
	end

	assign parity_low  = all_v[PAR_W-1:0];
	assign parity_high = all_v[MATCH_BITS-1:PAR_W];
	assign any_match   = |all_v;

endmodule

FILE: hdl/signed_row_combination_check.sv
// Top level: three-stage pipeline of compaction, parallel sign lanes and merge.
//
// Usage: an item on the item channel carries seven packed rows, a row mask
// and a target index; the result channel returns the 128 match bits split
// into parity_low and parity_high plus the any_match flag, one result per item.
// Both channels are valid/ready; a transfer happens when both are high.
// A result becomes valid once its item has passed the stage one and stage
// two registers into the stage three output register.
// Throughput is one item per clock while not stalled: stage one compacts the
// selected rows, stage two runs one lane per sign pattern (2^(NUM_ROWS-1)
// lanes) in parallel, stage three merges the lane hits and holds the result.
// Each stage advances whenever the stage after it is empty or moving, so
// bubbles close up while the receiver stalls, and the block keeps taking
// items until all three stages are full; a waiting result holds steady.
// Reset empties the pipeline at once; no result is shown after reset until
// an item has been taken. There is no configuration.
module signed_row_combination_check #(
	parameter int ENTRY_WIDTH = 8,
	parameter int NUM_ROWS    = 7
) (
	input logic          clk,
	input logic          arst_n,
	srcc_item_if.sink    item,
	srcc_result_if.source result
);
	import srcc_pkg::*;

	localparam int LANES = 1 << (NUM_ROWS - 1);

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	row_t                          rows [ROW_SLOTS];
	logic signed [ENTRY_WIDTH-1:0] picked_d [ROW_SLOTS][VEC_LEN];
	count_t                        count_d;
	logic                          tgt_ok;

	logic signed [ENTRY_WIDTH-1:0] picked_s1 [ROW_SLOTS][VEC_LEN];
	count_t                        count_s1;
	logic [TGT_W-1:0]              target_s1;

	lane_hit_t hits_d [LANES];
	lane_hit_t hits_s2 [LANES];
	count_t    count_s2;

	logic [PAR_W-1:0] low_d, high_d;
	logic             any_d;
	logic [PAR_W-1:0] low_s3, high_s3;
	logic             any_s3;

	// Stage enables ripple back from the result channel.
	assign en3        = !v_s3 || result.ready;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign item.ready = en1;

	assign rows[0] = item.row_zero;
	assign rows[1] = item.row_one;
	assign rows[2] = item.row_two;
	assign rows[3] = item.row_three;
	assign rows[4] = item.row_four;
	assign rows[5] = item.row_five;
	assign rows[6] = item.row_six;

	srcc_compact #(
		.ENTRY_WIDTH(ENTRY_WIDTH),
		.NUM_ROWS   (NUM_ROWS)
	) u_compact (
		.rows       (rows),
		.spread_mask(item.spread_mask),
		.picked     (picked_d),
		.count      (count_d)
	);

	// A target beyond the zero vector matches nothing: treat it as no rows.
	assign tgt_ok = item.target_index <= ZERO_TARGET;

	// Valid flags of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (en1) begin
			picked_s1 <= picked_d;
			count_s1  <= tgt_ok ? count_d : '0;
			target_s1 <= item.target_index;
		end
	end

	// One lane per sign pattern.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		srcc_lane #(
			.ENTRY_WIDTH(ENTRY_WIDTH),
			.NUM_ROWS   (NUM_ROWS),
			.LANE_IDX   (g)
		) u_lane (
			.picked      (picked_s1),
			.target_index(target_s1),
			.hit         (hits_d[g])
		);
	end

	// Stage two payload.
	always_ff @(posedge clk) begin
		if (en2) begin
			hits_s2  <= hits_d;
			count_s2 <= count_s1;
		end
	end

	srcc_merge #(
		.NUM_ROWS(NUM_ROWS)
	) u_merge (
		.hits       (hits_s2),
		.count      (count_s2),
		.parity_low (low_d),
		.parity_high(high_d),
		.any_match  (any_d)
	);

	// Stage three is the output register.
	always_ff @(posedge clk) begin
		if (en3) begin
			low_s3  <= low_d;
			high_s3 <= high_d;
			any_s3  <= any_d;
		end
	end

	assign result.valid       = v_s3;
	assign result.parity_low  = low_s3;
	assign result.parity_high = high_s3;
	assign result.any_match   = any_s3;

endmodule

FILE: hdl/srcc_check.sv
// Port-level checker for the signed row combination check, with its bind.
`include "signed_row_combination_check_macros.svh"

module srcc_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [srcc_pkg::PAR_W-1:0] parity_low,
	input logic [srcc_pkg::PAR_W-1:0] parity_high,
	input logic                       any_match
);
	import srcc_pkg::*;

	// The flag must agree with the match bits it summarizes.
	`SRCC_ASSERT_IMP(a_any_consistent, clk, arst_n, res_valid, any_match == ((|parity_low) || (|parity_high)))

	// A result that is not taken stays put.
	`SRCC_ASSERT_NEXT(a_stall_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(parity_low) && $stable(parity_high) && $stable(any_match))

	// With the output stage empty the pipeline always has room for an item.
	`SRCC_ASSERT_IMP(a_room_when_empty, clk, arst_n, !res_valid, item_ready)

	// Reset empties the output stage.
	`SRCC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !res_valid)

endmodule

bind signed_row_combination_check srcc_check u_srcc_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.parity_low (result.parity_low),
	.parity_high(result.parity_high),
	.any_match  (result.any_match)
);
